@@ sv/rbuv_pkg.sv @@
// rbuv_pkg: types, constants and helpers for the rotation-between-unit-vectors core
// used by rotation_between_unit_vectors_core; depends on nothing else
`default_nettype none

package rbuv_pkg;

    // fixed-point constants
    localparam int unsigned                ONE_Q14   = 16384;
    localparam logic signed [33:0]         DEN_ONE   = 34'sd268435456;  // 1.0 in Q.28
    localparam logic [14:0]                THR_RESET = 15'd16;

    // pipeline layout
    localparam int QUO_BITS   = 18;              // quotient bits kept, larger ones saturate
    localparam int DIV_N      = QUO_BITS + 1;    // setup stage plus one stage per bit
    localparam int DIV_FIRST  = 6;
    localparam int OUT_STAGE  = DIV_FIRST + DIV_N;
    localparam int PIPE_DEPTH = OUT_STAGE + 1;

    localparam int IN_W  = 96;
    localparam int OUT_W = 144;

    // identity matrix, r00 in the lowest bits
    localparam logic [OUT_W-1:0] IDENT_DATA =
        {16'h4000, 48'h0, 16'h4000, 48'h0, 16'h4000};

    // per-item values that travel alongside the nine division lanes
    typedef struct packed {
        logic               opp;
        logic [32:0]        dsr;    // 2 * (1 + c) in Q.28
        logic signed [18:0] vq_x;
        logic signed [18:0] vq_y;
        logic signed [18:0] vq_z;
    } side_t;

    // one restoring division lane
    typedef struct packed {
        logic                neg;
        logic                ovf;
        logic [32:0]         rem;
        logic [QUO_BITS-1:0] sh;    // numerator bits in, quotient bits out
    } lane_t;

    function automatic logic [15:0] sat16(input logic signed [20:0] x);
        logic [15:0] r;
        if (x > 21'sd32767)
            r = 16'h7fff;
        else if (x < -21'sd32768)
            r = 16'h8000;
        else
            r = x[15:0];
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/rotation_between_unit_vectors_core.sv @@
// rotation_between_unit_vectors_core: rotation matrix R = I + K + K*K / (1 + a.b)
// from two Q1.14 vectors, fully pipelined; depends on rbuv_pkg
`default_nettype none

// Takes one beat per clock: a beat of six Q1.14 components (a then b) gives one beat
// of the nine entries of R in Q1.14, saturated, row-major. The depth is set by the
// restoring divider that forms K*K / (1 + c): nine lanes in parallel, one quotient
// bit per stage over 18 stages plus a setup stage, after six stages of multiplies
// and sums and ahead of one output stage. When 1 + c is not above zero or falls
// below opposite_threshold (Q1.14, written through cfg_wr_en / cfg_wr_data, reset 16)
// the identity is sent with m_tuser set. Bubbles close up while the output is stalled,
// so s_tready drops only when all 26 stages hold a beat and m_tready is low.
module rotation_between_unit_vectors_core
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        cfg_wr_en,
    input  wire logic [14:0]                 cfg_wr_data,  // opposite_threshold

    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z (16 bits each, lowest first)
    input  wire logic [rbuv_pkg::IN_W-1:0]   s_tdata,

    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // r00, r01, r02, r10, r11, r12, r20, r21, r22 (16 bits each, lowest first)
    output logic [rbuv_pkg::OUT_W-1:0]       m_tdata,
    output logic                             m_tuser       // opposite_flag
);

    import rbuv_pkg::*;

    logic [14:0]            thr_reg;
    logic [PIPE_DEPTH-1:0]  valid_reg;
    logic [PIPE_DEPTH-1:0]  valid_in;
    logic [PIPE_DEPTH-1:0]  en;

    // stage 0: component products
    logic signed [31:0] ay_bz_reg, az_by_reg, az_bx_reg, ax_bz_reg, ax_by_reg, ay_bx_reg;
    logic signed [31:0] ax_bx_reg, ay_by_reg, az_bz_reg;
    // stage 1: cross product and 1 + dot
    logic signed [32:0] v_reg [3];
    logic signed [33:0] den_reg;
    // stage 2..5
    side_t              s2_side_reg, s3_side_reg, s4_side_reg, s5_side_reg;
    side_t              s2_side_next;
    logic signed [37:0] q_xx_reg, q_yy_reg, q_zz_reg, q_xy_reg, q_xz_reg, q_yz_reg;
    logic signed [37:0] kk_reg [9];
    logic signed [37:0] kk_next [9];
    logic               neg_reg [9];
    logic [35:0]        mag_reg [9];
    // divider
    lane_t              div_lane_reg [DIV_N][9];
    lane_t              div_lane_next [DIV_N][9];
    side_t              div_side_reg [DIV_N];
    // output
    logic [OUT_W-1:0]   out_data_reg, out_data_next;
    logic               out_opp_reg;

    // a stage may load when m_tready is high or when it or any stage after it has room
    always_comb
    begin
        valid_in = {valid_reg[PIPE_DEPTH-2:0], s_tvalid};
        for (int i = 0; i < PIPE_DEPTH; i++)
        begin
            en[i] = m_tready ||
                    !(&(valid_reg | ((PIPE_DEPTH'(1) << i) - PIPE_DEPTH'(1))));
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[OUT_STAGE];
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_opp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= THR_RESET;
            valid_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                thr_reg <= cfg_wr_data;
            for (int i = 0; i < PIPE_DEPTH; i++)
            begin
                if (en[i])
                    valid_reg[i] <= valid_in[i];
            end
        end
    end

    // stage 0
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ay_bz_reg <= $signed(s_tdata[31:16]) * $signed(s_tdata[95:80]);
            az_by_reg <= $signed(s_tdata[47:32]) * $signed(s_tdata[79:64]);
            az_bx_reg <= $signed(s_tdata[47:32]) * $signed(s_tdata[63:48]);
            ax_bz_reg <= $signed(s_tdata[15:0])  * $signed(s_tdata[95:80]);
            ax_by_reg <= $signed(s_tdata[15:0])  * $signed(s_tdata[79:64]);
            ay_bx_reg <= $signed(s_tdata[31:16]) * $signed(s_tdata[63:48]);
            ax_bx_reg <= $signed(s_tdata[15:0])  * $signed(s_tdata[63:48]);
            ay_by_reg <= $signed(s_tdata[31:16]) * $signed(s_tdata[79:64]);
            az_bz_reg <= $signed(s_tdata[47:32]) * $signed(s_tdata[95:80]);
        end
    end

    // stage 1
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            v_reg[0] <= 33'(ay_bz_reg) - 33'(az_by_reg);
            v_reg[1] <= 33'(az_bx_reg) - 33'(ax_bz_reg);
            v_reg[2] <= 33'(ax_by_reg) - 33'(ay_bx_reg);
            den_reg  <= DEN_ONE + 34'(ax_bx_reg) + 34'(ay_by_reg) + 34'(az_bz_reg);
        end
    end

    // stage 2: round v to Q.14, ties away from zero, and the opposite test
    always_comb
    begin
        logic [31:0]        vmag;
        logic [31:0]        vsum;
        logic signed [18:0] vq [3];
        for (int i = 0; i < 3; i++)
        begin
            vmag  = v_reg[i][32] ? 32'(-v_reg[i]) : v_reg[i][31:0];
            vsum  = vmag + 32'd8192;
            vq[i] = v_reg[i][32] ? -$signed({1'b0, vsum[31:14]}) : $signed({1'b0, vsum[31:14]});
        end
        s2_side_next.vq_x = vq[0];
        s2_side_next.vq_y = vq[1];
        s2_side_next.vq_z = vq[2];
        s2_side_next.dsr  = {den_reg[31:0], 1'b0};
        s2_side_next.opp  = (den_reg <= 34'sd0) ||
                            (den_reg < $signed({5'd0, thr_reg, 14'd0}));
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
            s2_side_reg <= s2_side_next;
    end

    // stage 3: outer product of vq
    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            q_xx_reg    <= s2_side_reg.vq_x * s2_side_reg.vq_x;
            q_yy_reg    <= s2_side_reg.vq_y * s2_side_reg.vq_y;
            q_zz_reg    <= s2_side_reg.vq_z * s2_side_reg.vq_z;
            q_xy_reg    <= s2_side_reg.vq_x * s2_side_reg.vq_y;
            q_xz_reg    <= s2_side_reg.vq_x * s2_side_reg.vq_z;
            q_yz_reg    <= s2_side_reg.vq_y * s2_side_reg.vq_z;
            s3_side_reg <= s2_side_reg;
        end
    end

    // stage 4: K*K = vq vq^T - |vq|^2 I
    always_comb
    begin
        kk_next[0] = -(q_yy_reg + q_zz_reg);
        kk_next[1] = q_xy_reg;
        kk_next[2] = q_xz_reg;
        kk_next[3] = q_xy_reg;
        kk_next[4] = -(q_xx_reg + q_zz_reg);
        kk_next[5] = q_yz_reg;
        kk_next[6] = q_xz_reg;
        kk_next[7] = q_yz_reg;
        kk_next[8] = -(q_xx_reg + q_yy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            kk_reg      <= kk_next;
            s4_side_reg <= s3_side_reg;
        end
    end

    // stage 5: sign and magnitude
    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            for (int e = 0; e < 9; e++)
            begin
                neg_reg[e] <= kk_reg[e][37];
                mag_reg[e] <= kk_reg[e][37] ? 36'(-kk_reg[e]) : kk_reg[e][35:0];
            end
            s5_side_reg <= s4_side_reg;
        end
    end

    // divider setup and steps; numerator 2*|kk|*2^14 + den over 2*den
    always_comb
    begin
        logic [50:0] num;
        logic [33:0] shifted;
        logic [33:0] dext;
        for (int e = 0; e < 9; e++)
        begin
            num = {mag_reg[e], 15'd0} + 51'(s5_side_reg.dsr[32:1]);
            div_lane_next[0][e].neg = neg_reg[e];
            div_lane_next[0][e].rem = num[50:QUO_BITS];
            div_lane_next[0][e].ovf = num[50:QUO_BITS] >= s5_side_reg.dsr;
            div_lane_next[0][e].sh  = num[QUO_BITS-1:0];
        end
        for (int s = 1; s < DIV_N; s++)
        begin
            dext = {1'b0, div_side_reg[s-1].dsr};
            for (int e = 0; e < 9; e++)
            begin
                shifted = {div_lane_reg[s-1][e].rem, div_lane_reg[s-1][e].sh[QUO_BITS-1]};
                div_lane_next[s][e].neg = div_lane_reg[s-1][e].neg;
                div_lane_next[s][e].ovf = div_lane_reg[s-1][e].ovf;
                if (shifted >= dext)
                begin
                    div_lane_next[s][e].rem = 33'(shifted - dext);
                    div_lane_next[s][e].sh  = {div_lane_reg[s-1][e].sh[QUO_BITS-2:0], 1'b1};
                end
                else
                begin
                    div_lane_next[s][e].rem = shifted[32:0];
                    div_lane_next[s][e].sh  = {div_lane_reg[s-1][e].sh[QUO_BITS-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_N; s++)
        begin
            if (en[DIV_FIRST + s])
            begin
                div_lane_reg[s] <= div_lane_next[s];
                div_side_reg[s] <= (s == 0) ? s5_side_reg : div_side_reg[(s == 0) ? 0 : s - 1];
            end
        end
    end

    // output stage: I + K + quotient, saturated, or the identity for an opposite beat
    always_comb
    begin
        side_t              sd;
        logic signed [20:0] kv [9];
        logic [18:0]        qmag;
        logic signed [20:0] t;
        logic signed [20:0] id;
        logic [OUT_W-1:0]   d;
        sd    = div_side_reg[DIV_N-1];
        kv[0] = 21'sd0;
        kv[1] = -21'(sd.vq_z);
        kv[2] = 21'(sd.vq_y);
        kv[3] = 21'(sd.vq_z);
        kv[4] = 21'sd0;
        kv[5] = -21'(sd.vq_x);
        kv[6] = -21'(sd.vq_y);
        kv[7] = 21'(sd.vq_x);
        kv[8] = 21'sd0;
        d     = '0;
        for (int e = 0; e < 9; e++)
        begin
            // quotients of 2^18 or more saturate the entry either way
            qmag = div_lane_reg[DIV_N-1][e].ovf ? 19'h40000
                                                 : {1'b0, div_lane_reg[DIV_N-1][e].sh};
            t    = div_lane_reg[DIV_N-1][e].neg ? -$signed({2'b0, qmag})
                                                 : $signed({2'b0, qmag});
            id   = (e == 0 || e == 4 || e == 8) ? 21'(ONE_Q14) : 21'sd0;
            d[16*e +: 16] = sat16(id + kv[e] + t);
        end
        out_data_next = sd.opp ? IDENT_DATA : d;
    end

    always_ff @(posedge clk)
    begin
        if (en[OUT_STAGE])
        begin
            out_data_reg <= out_data_next;
            out_opp_reg  <= div_side_reg[DIV_N-1].opp;
        end
    end

`ifndef ASSERT_OFF
    // input side stalls only when every stage is occupied and the output is held
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> ((&valid_reg) && !m_tready))
        else $error("input stalled with room in the pipeline");

    // an accepted beat with nothing leaving raises occupancy by one
    a_occupancy_up: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !(m_tvalid && m_tready)) |=>
        ($countones(valid_reg) == $past($countones(valid_reg)) + 1))
        else $error("beat lost or duplicated in pipeline");

    // a beat leaving with nothing entering lowers occupancy by one
    a_occupancy_down: assert property (@(posedge clk) disable iff (!rst_n)
        (!(s_tvalid && s_tready) && m_tvalid && m_tready) |=>
        ($countones(valid_reg) + 1 == $past($countones(valid_reg))))
        else $error("beat lost or duplicated in pipeline");

    // opposite vectors give the identity
    a_opp_identity: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == IDENT_DATA))
        else $error("opposite beat without identity matrix");
`endif

endmodule

`default_nettype wire
